// ===== rtl/core/gpp_pkg.sv =====
package gpp_pkg;

    // Default sizing of the port
    localparam int LATCH_CYCLES_DEF = 10205;
    localparam int STICKS_DEF       = 2;
    localparam int BUTTONS_DEF      = 3;
    localparam int QUEUE_DEPTH_DEF  = 2;

    // Fixed field widths
    localparam int OP_W      = 3;
    localparam int ADDR_W    = 8;
    localparam int BUS_W     = 8;
    localparam int CYCLES_W  = 16;
    localparam int IDX_W     = 2;
    localparam int POS_W     = 8;
    localparam int TRIM_W    = 9;
    localparam int ELAPSED_W = 12;
    localparam int LATCH_W   = 14;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 9;

    // Operation codes
    localparam logic [OP_W-1:0] OP_BUS_ACCESS = 3'd0;
    localparam logic [OP_W-1:0] OP_TICK       = 3'd1;
    localparam logic [OP_W-1:0] OP_SET_AXIS   = 3'd2;
    localparam logic [OP_W-1:0] OP_SET_BUTTON = 3'd3;
    localparam logic [OP_W-1:0] OP_RESET      = 3'd4;

    // I/O page low-byte addresses
    localparam logic [ADDR_W-1:0] ADDR_BUTTON_FIRST = 8'h61;
    localparam logic [ADDR_W-1:0] ADDR_BUTTON_LAST  = 8'h63;
    localparam logic [ADDR_W-1:0] ADDR_PADDLE_FIRST = 8'h64;
    localparam logic [ADDR_W-1:0] ADDR_PADDLE_LAST  = 8'h67;
    localparam logic [ADDR_W-1:0] ADDR_STROBE       = 8'h70;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TRIM_H = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIM_V = 1'd1;

    // Misc constants
    localparam logic [POS_W-1:0]     CENTRE_POS  = 8'd127;
    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = 12'd4095;
    localparam logic [BUS_W-1:0]     LOW_BITS    = 8'h7F;
    localparam logic [BUS_W-1:0]     HIGH_BIT    = 8'h80;
    localparam logic [POS_W-1:0]     POS_MAX     = 8'd255;
    localparam logic [ELAPSED_W-1:0] PADDLE_MUL  = 12'd11;
    localparam logic [ELAPSED_W-1:0] PADDLE_ADD  = 12'd10;

    // Classified command kinds
    typedef enum logic [3:0] {
        CMD_BUTTON_READ,
        CMD_PADDLE_READ,
        CMD_STROBE,
        CMD_PASS,
        CMD_TICK,
        CMD_SET_AXIS,
        CMD_SET_BUTTON,
        CMD_CLEAR,
        CMD_ERROR
    } cmd_kind_t;

    // Command handed from front to back
    typedef struct packed {
        cmd_kind_t           kind;
        logic                err;
        logic [IDX_W-1:0]    idx;
        logic                is_y;
        logic [BUS_W-1:0]    bus;
        logic [POS_W-1:0]    pos;
        logic                pressed;
        logic [CYCLES_W-1:0] cycles;
    } gpp_cmd_t;

endpackage

// ===== rtl/core/gpp_if.sv =====
// Input item channel
interface gpp_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  op;
    logic [7:0]  address;
    logic [7:0]  floating_bus;
    logic [15:0] tick_cycles;
    logic [1:0]  stick_index;
    logic [1:0]  axis_select;
    logic [7:0]  position;
    logic [1:0]  button_sel;
    logic        pressed;

    modport source (output valid, op, address, floating_bus, tick_cycles, stick_index,
                    axis_select, position, button_sel, pressed, input ready);
    modport sink   (input valid, op, address, floating_bus, tick_cycles, stick_index,
                    axis_select, position, button_sel, pressed, output ready);
endinterface

// Result item channel
interface gpp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       error;

    modport source (output valid, read_data, error, input ready);
    modport sink   (input valid, read_data, error, output ready);
endinterface

// ===== rtl/core/game_port_paddle_button_io_unit.sv =====
// Game port paddle/button unit.
// A transaction passes through a short command queue between decode and execute; the
// execute stage writes its result into the result register, from which it is offered.
// Throughput: one transaction per cycle while the queue has room; the execute stage
// retires one per cycle while the result register drains.
// Reset (rst_n low, asynchronous): trims zero, positions centred at 127, buttons and
// latches cleared, paddle timer expired, queue and result register empty.
module game_port_paddle_button_io_unit #(
    parameter int LATCH_CYCLES = gpp_pkg::LATCH_CYCLES_DEF,
    parameter int STICKS       = gpp_pkg::STICKS_DEF,
    parameter int BUTTONS      = gpp_pkg::BUTTONS_DEF,
    parameter int QUEUE_DEPTH  = gpp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    gpp_in_if.sink                          req,
    gpp_out_if.source                       rsp,
    input  logic                            cfg_we,
    input  logic [gpp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [gpp_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import gpp_pkg::*;

    gpp_cmd_t front_cmd;
    gpp_cmd_t head_cmd;
    logic     push;
    logic     pop;
    logic     q_full;
    logic     q_not_empty;

    // Decode and classify
    gpp_front #(
        .STICKS  (STICKS),
        .BUTTONS (BUTTONS)
    ) u_front (
        .req    (req),
        .q_full (q_full),
        .push   (push),
        .cmd    (front_cmd)
    );

    // Command queue
    gpp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (front_cmd),
        .full      (q_full),
        .not_empty (q_not_empty),
        .pop       (pop),
        .head_cmd  (head_cmd)
    );

    // Execute against device state
    gpp_back #(
        .LATCH_CYCLES (LATCH_CYCLES),
        .STICKS       (STICKS),
        .BUTTONS      (BUTTONS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .q_not_empty (q_not_empty),
        .cmd         (head_cmd),
        .pop         (pop),
        .rsp         (rsp)
    );

endmodule

// ===== rtl/core/gpp_front.sv =====
module gpp_front #(
    parameter int STICKS  = gpp_pkg::STICKS_DEF,
    parameter int BUTTONS = gpp_pkg::BUTTONS_DEF
) (
    gpp_in_if.sink              req,
    input  logic                q_full,
    output logic                push,
    output gpp_pkg::gpp_cmd_t   cmd
);
    import gpp_pkg::*;

    logic [ADDR_W-1:0] btn_offset;

    assign req.ready  = !q_full;
    assign push       = req.valid && !q_full;
    assign btn_offset = req.address - ADDR_BUTTON_FIRST;

    // Classify the incoming transaction
    always_comb
    begin
        cmd.kind    = CMD_ERROR;
        cmd.err     = 1'b0;
        cmd.idx     = '0;
        cmd.is_y    = 1'b0;
        cmd.bus     = req.floating_bus;
        cmd.pos     = req.position;
        cmd.pressed = req.pressed;
        cmd.cycles  = req.tick_cycles;
        unique case (req.op)
            OP_BUS_ACCESS:
            begin
                if (req.address >= ADDR_BUTTON_FIRST && req.address <= ADDR_BUTTON_LAST)
                begin
                    cmd.kind = CMD_BUTTON_READ;
                    cmd.idx  = btn_offset[IDX_W-1:0];
                    cmd.err  = (32'(btn_offset) >= BUTTONS);
                end
                else if (req.address >= ADDR_PADDLE_FIRST && req.address <= ADDR_PADDLE_LAST)
                begin
                    cmd.kind = CMD_PADDLE_READ;
                    cmd.idx  = {1'b0, req.address[1]};
                    cmd.is_y = req.address[0];
                    cmd.err  = (32'(req.address[1]) >= STICKS);
                end
                else if (req.address == ADDR_STROBE)
                begin
                    cmd.kind = CMD_STROBE;
                end
                else
                begin
                    cmd.kind = CMD_PASS;
                end
            end
            OP_TICK:
            begin
                cmd.kind = CMD_TICK;
            end
            OP_SET_AXIS:
            begin
                if (32'(req.stick_index) >= STICKS || req.axis_select > 2'd1)
                begin
                    cmd.kind = CMD_ERROR;
                end
                else
                begin
                    cmd.kind = CMD_SET_AXIS;
                    cmd.idx  = req.stick_index;
                    cmd.is_y = req.axis_select[0];
                end
            end
            OP_SET_BUTTON:
            begin
                if (32'(req.button_sel) >= BUTTONS)
                begin
                    cmd.kind = CMD_ERROR;
                end
                else
                begin
                    cmd.kind = CMD_SET_BUTTON;
                    cmd.idx  = req.button_sel;
                end
            end
            OP_RESET:
            begin
                cmd.kind = CMD_CLEAR;
            end
            default:
            begin
                cmd.kind = CMD_ERROR;
            end
        endcase
    end

endmodule

// ===== rtl/core/gpp_queue.sv =====
module gpp_queue #(
    parameter int DEPTH = gpp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  gpp_pkg::gpp_cmd_t   push_cmd,
    output logic                full,
    output logic                not_empty,
    input  logic                pop,
    output gpp_pkg::gpp_cmd_t   head_cmd
);
    import gpp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    gpp_cmd_t            entry_reg [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]    count_reg, count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_cmd  = entry_reg[rd_ptr_reg];

    // Pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full && !pop))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("queue read while empty");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

endmodule

// ===== rtl/core/gpp_back.sv =====
module gpp_back #(
    parameter int LATCH_CYCLES = gpp_pkg::LATCH_CYCLES_DEF,
    parameter int STICKS       = gpp_pkg::STICKS_DEF,
    parameter int BUTTONS      = gpp_pkg::BUTTONS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [gpp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [gpp_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                q_not_empty,
    input  gpp_pkg::gpp_cmd_t                   cmd,
    output logic                                pop,
    gpp_out_if.source                           rsp
);
    import gpp_pkg::*;

    localparam int STK_W = (STICKS > 1) ? $clog2(STICKS) : 1;
    localparam int BTN_W = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;

    logic signed [TRIM_W-1:0] trim_h_reg, trim_v_reg;
    logic [ELAPSED_W-1:0]     elapsed_reg, elapsed_next;
    logic [POS_W-1:0]         x_pos_reg [STICKS];
    logic [POS_W-1:0]         y_pos_reg [STICKS];
    logic [BUTTONS-1:0]       down_reg, down_next;
    logic [LATCH_W-1:0]       latch_reg [BUTTONS];
    logic [LATCH_W-1:0]       latch_next [BUTTONS];
    logic                     out_valid_reg;
    logic [BUS_W-1:0]         out_data_reg, out_data_next;
    logic                     out_err_reg, out_err_next;

    logic [STK_W-1:0]         stk;
    logic [BTN_W-1:0]         btn;
    logic [POS_W-1:0]         pos_sel;
    logic signed [TRIM_W-1:0] trim_sel;
    logic signed [TRIM_W:0]   pos_sum;
    logic [POS_W-1:0]         pos_clamp;
    logic [ELAPSED_W-1:0]     limit;
    logic [CYCLES_W:0]        elapsed_sum;

    assign pop       = q_not_empty && (!out_valid_reg || rsp.ready);
    assign rsp.valid = out_valid_reg;
    assign rsp.read_data = out_data_reg;
    assign rsp.error = out_err_reg;

    assign stk = cmd.idx[STK_W-1:0];
    assign btn = cmd.idx[BTN_W-1:0];

    // Paddle one-shot compare: clamp(pos + trim) * 11 + 10
    assign pos_sel  = cmd.is_y ? y_pos_reg[stk] : x_pos_reg[stk];
    assign trim_sel = cmd.is_y ? trim_v_reg : trim_h_reg;
    assign pos_sum  = $signed({2'b00, pos_sel}) + {trim_sel[TRIM_W-1], trim_sel};
    always_comb
    begin
        if (pos_sum < 0)
        begin
            pos_clamp = '0;
        end
        else if (pos_sum > $signed({2'b00, POS_MAX}))
        begin
            pos_clamp = POS_MAX;
        end
        else
        begin
            pos_clamp = pos_sum[POS_W-1:0];
        end
    end
    assign limit = {4'b0000, pos_clamp} * PADDLE_MUL + PADDLE_ADD;

    // Saturating elapsed count
    assign elapsed_sum = {5'b00000, elapsed_reg} + {1'b0, cmd.cycles};

    // Execute one command
    always_comb
    begin
        elapsed_next  = elapsed_reg;
        down_next     = down_reg;
        latch_next    = latch_reg;
        out_data_next = '0;
        out_err_next  = cmd.err;
        case (cmd.kind)
            CMD_BUTTON_READ:
            begin
                out_data_next = cmd.bus & LOW_BITS;
                if (!cmd.err && (down_reg[btn] || latch_reg[btn] != '0))
                begin
                    out_data_next = out_data_next | HIGH_BIT;
                end
            end
            CMD_PADDLE_READ:
            begin
                out_data_next = cmd.bus & LOW_BITS;
                if (!cmd.err && elapsed_reg < limit)
                begin
                    out_data_next = out_data_next | HIGH_BIT;
                end
            end
            CMD_STROBE:
            begin
                out_data_next = cmd.bus;
                elapsed_next  = '0;
            end
            CMD_PASS:
            begin
                out_data_next = cmd.bus;
            end
            CMD_TICK:
            begin
                elapsed_next = (elapsed_sum > {5'b00000, ELAPSED_MAX}) ?
                               ELAPSED_MAX : elapsed_sum[ELAPSED_W-1:0];
                for (int i = 0; i < BUTTONS; i++)
                begin
                    latch_next[i] = ({2'b00, latch_reg[i]} > cmd.cycles) ?
                                    latch_reg[i] - cmd.cycles[LATCH_W-1:0] : '0;
                end
            end
            CMD_SET_BUTTON:
            begin
                if (cmd.pressed && !down_reg[btn])
                begin
                    latch_next[btn] = LATCH_W'(LATCH_CYCLES);
                end
                down_next[btn] = cmd.pressed;
            end
            CMD_CLEAR:
            begin
                elapsed_next = ELAPSED_MAX;
                down_next    = '0;
                for (int i = 0; i < BUTTONS; i++)
                begin
                    latch_next[i] = '0;
                end
            end
            CMD_ERROR:
            begin
                out_err_next = 1'b1;
            end
            default:
            begin
                out_err_next = cmd.err;
            end
        endcase
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trim_h_reg <= '0;
            trim_v_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TRIM_H: trim_h_reg <= $signed(cfg_data);
                CFG_TRIM_V: trim_v_reg <= $signed(cfg_data);
                default:    trim_h_reg <= trim_h_reg;
            endcase
        end
    end

    // Device state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elapsed_reg <= ELAPSED_MAX;
            down_reg    <= '0;
            for (int i = 0; i < BUTTONS; i++)
            begin
                latch_reg[i] <= '0;
            end
            for (int i = 0; i < STICKS; i++)
            begin
                x_pos_reg[i] <= CENTRE_POS;
                y_pos_reg[i] <= CENTRE_POS;
            end
        end
        else if (pop)
        begin
            elapsed_reg <= elapsed_next;
            down_reg    <= down_next;
            latch_reg   <= latch_next;
            if (cmd.kind == CMD_SET_AXIS)
            begin
                if (cmd.is_y)
                begin
                    y_pos_reg[stk] <= cmd.pos;
                end
                else
                begin
                    x_pos_reg[stk] <= cmd.pos;
                end
            end
            else if (cmd.kind == CMD_CLEAR)
            begin
                for (int i = 0; i < STICKS; i++)
                begin
                    x_pos_reg[i] <= CENTRE_POS;
                    y_pos_reg[i] <= CENTRE_POS;
                end
            end
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_data_reg <= out_data_next;
            out_err_reg  <= out_err_next;
        end
    end

    a_strobe_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && cmd.kind == CMD_STROBE) |=> (elapsed_reg == '0))
        else $error("strobe did not restart the timer");

    a_clear_state: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && cmd.kind == CMD_CLEAR) |=> (elapsed_reg == ELAPSED_MAX && down_reg == '0))
        else $error("state clear incomplete");

    a_press_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && cmd.kind == CMD_SET_BUTTON && cmd.pressed && !down_reg[btn])
        |=> (latch_reg[$past(btn)] == LATCH_W'(LATCH_CYCLES)))
        else $error("press edge did not load latch");

    a_no_result_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !rsp.ready) |=> out_valid_reg)
        else $error("pending result lost");

endmodule
